// ----- hdl/psn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psn_pkg;

	// Field widths
	localparam int unsigned PPS_W   = 8;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ETU_W   = 13;
	localparam int unsigned PROTO_W = 2;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned FVAL_W  = 13;
	localparam int unsigned DVAL_W  = 8;
	localparam int unsigned MAG_W   = 12;
	localparam int unsigned DMAG_W  = 7;

	// Stream payload widths
	localparam int unsigned S_TDATA_W = 88;
	localparam int unsigned S_TUSER_W = 1;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned M_TUSER_W = 3;

	// Protocol values
	localparam logic [PROTO_W-1:0] PROTO_NOT_SET = 2'd2;
	localparam logic [BYTE_W-1:0]  PPSS_BYTE     = 8'hFF;
	localparam logic [3:0]         PPS0_HIGH     = 4'h1;
	localparam logic [PPS_W-1:0]   PPS1_DEFAULT  = 8'h11;
	localparam logic [3:0]         D_CODE_ONE    = 4'd1;

	// Operation selector on the input stream
	localparam logic OP_START    = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEND       = 3'd0,
		KIND_NEGOTIATED = 3'd1,
		KIND_DONE       = 3'd2,
		KIND_FAILED     = 3'd3,
		KIND_UNEXPECTED = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_OUT
	} psn_state_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic div_start;
		logic out_load;
	} psn_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
		logic out_free;
	} psn_sts_t;

	// Clock rate conversion factor F per code; reserved codes give -1
	function automatic logic signed [FVAL_W-1:0] f_value(input logic [3:0] code);
		logic signed [FVAL_W-1:0] v;
		unique case (code)
			4'd0, 4'd1: v = 13'sd372;
			4'd2:       v = 13'sd558;
			4'd3:       v = 13'sd744;
			4'd4:       v = 13'sd1116;
			4'd5:       v = 13'sd1488;
			4'd6:       v = 13'sd1860;
			4'd9:       v = 13'sd512;
			4'd10:      v = 13'sd768;
			4'd11:      v = 13'sd1024;
			4'd12:      v = 13'sd1536;
			4'd13:      v = 13'sd2048;
			default:    v = -13'sd1;
		endcase
		return v;
	endfunction

	// Baud rate adjustment factor D per code; reserved codes give -1
	function automatic logic signed [DVAL_W-1:0] d_value(input logic [3:0] code);
		logic signed [DVAL_W-1:0] v;
		unique case (code)
			4'd1:    v = 8'sd1;
			4'd2:    v = 8'sd2;
			4'd3:    v = 8'sd4;
			4'd4:    v = 8'sd8;
			4'd5:    v = 8'sd16;
			4'd6:    v = 8'sd32;
			4'd7:    v = 8'sd64;
			4'd8:    v = 8'sd12;
			4'd9:    v = 8'sd20;
			default: v = -8'sd1;
		endcase
		return v;
	endfunction

	// Code of the next smaller D; code 1 when none is smaller or code is reserved
	function automatic logic [3:0] smaller_d(input logic [3:0] code);
		logic [3:0] v;
		unique case (code)
			4'd3:    v = 4'd2;
			4'd4:    v = 4'd3;
			4'd8:    v = 4'd4;
			4'd5:    v = 4'd8;
			4'd9:    v = 4'd5;
			4'd6:    v = 4'd9;
			4'd7:    v = 4'd6;
			default: v = 4'd1;
		endcase
		return v;
	endfunction

	// PPSS, PPS0, PPS1 and the XOR check byte, first byte high
	function automatic logic [WORD_W-1:0] build_request(input logic [3:0] t,
		input logic [PPS_W-1:0] pps1);
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] pck;
		b1  = {PPS0_HIGH, t};
		pck = PPSS_BYTE ^ b1 ^ pps1;
		return {PPSS_BYTE, b1, pps1, pck};
	endfunction

endpackage

`default_nettype wire

// ----- hdl/psn_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psn_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [psn_pkg::FVAL_W-1:0]    dividend,
	input  wire logic signed [psn_pkg::DVAL_W-1:0]    divisor,
	output logic                                      busy,
	output logic signed [psn_pkg::ETU_W-1:0]          quotient
);
	import psn_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAG_W);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MAG_W-1:0]    dvd_q;
	logic [DMAG_W-1:0]   dvs_q;
	logic [DMAG_W-1:0]   rem_q;
	logic                neg_q;

	logic [FVAL_W-1:0]   f_abs;
	logic [DVAL_W-1:0]   d_abs;
	logic [DMAG_W:0]     rem_sh;
	logic                fits;
	logic [DMAG_W:0]     rem_sub;

	// Take magnitudes of the operands
	always_comb begin
		f_abs = dividend[FVAL_W-1] ? (~dividend + 1'b1) : dividend;
		d_abs = divisor[DVAL_W-1] ? (~divisor + 1'b1) : divisor;
	end

	// One restoring step: shift in a dividend bit, subtract when it fits
	always_comb begin
		rem_sh  = {rem_q, dvd_q[MAG_W-1]};
		fits    = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MAG_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= f_abs[MAG_W-1:0];
			dvs_q <= d_abs[DMAG_W-1:0];
			rem_q <= '0;
			neg_q <= dividend[FVAL_W-1] ^ divisor[DVAL_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[MAG_W-2:0], fits};
			rem_q <= fits ? rem_sub[DMAG_W-1:0] : rem_sh[DMAG_W-1:0];
		end
	end

	// Apply the sign; truncation toward zero follows from dividing magnitudes
	assign quotient = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign busy     = busy_q;

endmodule

`default_nettype wire

// ----- hdl/psn_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psn_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire psn_pkg::psn_cmd_t                    cmd,
	output psn_pkg::psn_sts_t                         sts,
	input  wire logic [psn_pkg::S_TDATA_W-1:0]        in_data,
	input  wire logic [psn_pkg::S_TUSER_W-1:0]        in_user,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [psn_pkg::M_TDATA_W-1:0]             out_data,
	output logic [psn_pkg::M_TUSER_W-1:0]             out_user
);
	import psn_pkg::*;

	// Latched input item
	logic                op_q;
	logic [PPS_W-1:0]    req_q;
	logic                link_q;
	logic [LEN_W-1:0]    alen_q;
	logic [BYTE_W-1:0]   t0_q;
	logic [BYTE_W-1:0]   ta1_q;
	logic [BYTE_W-1:0]   third_q;
	logic [BYTE_W-1:0]   fourth_q;
	logic [BYTE_W-1:0]   fifth_q;
	logic [WORD_W-1:0]   resp_q;

	// Negotiation state
	logic                await_q;
	logic [PPS_W-1:0]    orig_q;
	logic [PPS_W-1:0]    cur_q;
	logic [3:0]          ptype_q;
	logic [WORD_W-1:0]   sent_q;

	// Pending result
	kind_t               res_kind_q;
	logic [WORD_W-1:0]   res_word_q;
	logic [PPS_W-1:0]    res_pps1_q;
	logic [PROTO_W-1:0]  res_proto_q;
	logic                res_div_q;

	// Output register
	logic                out_full_q;
	kind_t               out_kind_q;
	logic [WORD_W-1:0]   out_word_q;
	logic [PPS_W-1:0]    out_pps1_q;
	logic [ETU_W-1:0]    out_etu_q;
	logic [PROTO_W-1:0]  out_proto_q;

	// Evaluation results
	kind_t               e_kind;
	logic [WORD_W-1:0]   e_word;
	logic [PPS_W-1:0]    e_pps1;
	logic [PROTO_W-1:0]  e_proto;
	logic                e_div;
	logic                await_d;
	logic                wr_start;
	logic                wr_retry;
	logic [PPS_W-1:0]    merged;
	logic [3:0]          t_sel;
	logic [PPS_W-1:0]    retry_pps1;
	logic                div_busy;
	logic signed [ETU_W-1:0] div_quot;

	// Capture an accepted input transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_user[0];
			req_q    <= in_data[7:0];
			link_q   <= in_data[8];
			alen_q   <= in_data[14:9];
			t0_q     <= in_data[22:15];
			ta1_q    <= in_data[30:23];
			third_q  <= in_data[38:31];
			fourth_q <= in_data[46:39];
			fifth_q  <= in_data[54:47];
			resp_q   <= in_data[86:55];
		end
	end

	// Decide the result and the state update for the latched item
	always_comb begin
		logic [3:0]  fr;
		logic [3:0]  dr;
		logic [3:0]  fi;
		logic [3:0]  di;
		logic [3:0]  fn;
		logic [3:0]  dn;
		logic        nego;
		logic [2:0]  idx;
		logic [BYTE_W-1:0] td1;

		fr   = req_q[7:4];
		dr   = req_q[3:0];
		fi   = ta1_q[7:4];
		di   = ta1_q[3:0];
		fn   = (f_value(fr) > f_value(fi)) ? fi : fr;
		dn   = (d_value(dr) > d_value(di)) ? di : dr;
		nego = t0_q[4] && (alen_q >= LEN_W'(2));
		idx  = 3'd2 + {2'b0, t0_q[4]} + {2'b0, t0_q[5]} + {2'b0, t0_q[6]};
		unique case (idx)
			3'd2:    td1 = ta1_q;
			3'd3:    td1 = third_q;
			3'd4:    td1 = fourth_q;
			default: td1 = fifth_q;
		endcase
		merged = nego ? {fn, dn} : PPS1_DEFAULT;
		t_sel  = 4'd0;
		if (t0_q[7]) begin
			if (!td1[4]) begin
				t_sel = td1[3:0];
			end else begin
				nego = 1'b0;
			end
		end
		retry_pps1 = {cur_q[7:4], smaller_d(cur_q[3:0])};

		e_kind   = KIND_FAILED;
		e_word   = '0;
		e_pps1   = '0;
		e_proto  = PROTO_NOT_SET;
		e_div    = 1'b0;
		await_d  = 1'b0;
		wr_start = 1'b0;
		wr_retry = 1'b0;

		if (op_q == OP_START) begin
			if (!link_q) begin
				e_kind = KIND_FAILED;
			end else if (req_q == '0) begin
				e_kind = KIND_DONE;
			end else if (nego) begin
				e_kind   = KIND_SEND;
				e_word   = build_request(t_sel, merged);
				await_d  = 1'b1;
				wr_start = 1'b1;
			end else begin
				e_kind = KIND_DONE;
				e_pps1 = merged;
			end
		end else begin
			if (!await_q) begin
				e_kind  = KIND_UNEXPECTED;
				await_d = await_q;
			end else if (!link_q) begin
				e_kind = KIND_FAILED;
			end else if (resp_q == sent_q) begin
				e_kind  = KIND_NEGOTIATED;
				e_pps1  = cur_q;
				e_proto = (ptype_q <= 4'd1) ? ptype_q[PROTO_W-1:0] : PROTO_NOT_SET;
				e_div   = 1'b1;
			end else if (cur_q[3:0] == D_CODE_ONE) begin
				e_kind = KIND_DONE;
				e_pps1 = orig_q;
			end else begin
				e_kind   = KIND_SEND;
				e_word   = build_request(ptype_q, retry_pps1);
				await_d  = 1'b1;
				wr_retry = 1'b1;
			end
		end
	end

	// Commit the negotiation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= 1'b0;
			orig_q  <= '0;
			cur_q   <= '0;
			ptype_q <= '0;
			sent_q  <= '0;
		end else if (cmd.eval) begin
			await_q <= await_d;
			if (wr_start) begin
				orig_q  <= req_q;
				cur_q   <= merged;
				ptype_q <= t_sel;
				sent_q  <= e_word;
			end else if (wr_retry) begin
				cur_q  <= retry_pps1;
				sent_q <= e_word;
			end
		end
	end

	// Hold the pending result while the divider runs
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			res_kind_q  <= e_kind;
			res_word_q  <= e_word;
			res_pps1_q  <= e_pps1;
			res_proto_q <= e_proto;
			res_div_q   <= e_div;
		end
	end

	// ETU = F / D of the current PPS1
	psn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (f_value(cur_q[7:4])),
		.divisor  (d_value(cur_q[3:0])),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind_q  <= res_kind_q;
			out_word_q  <= res_word_q;
			out_pps1_q  <= res_pps1_q;
			out_etu_q   <= res_div_q ? div_quot : '0;
			out_proto_q <= res_proto_q;
		end
	end

	assign out_valid = out_full_q;
	assign out_data  = {1'b0, out_proto_q, out_etu_q, out_pps1_q, out_word_q};
	assign out_user  = out_kind_q;

	assign sts.need_div = e_div;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_full_q || out_ready;

endmodule

`default_nettype wire

// ----- hdl/psn_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psn_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire psn_pkg::psn_sts_t     sts,
	output psn_pkg::psn_cmd_t          cmd
);
	import psn_pkg::*;

	psn_state_t state_q;
	psn_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = sts.need_div ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (!sts.div_busy) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_EVAL: begin
				cmd.eval      = 1'b1;
				cmd.div_start = sts.need_div;
			end
			ST_DIV: begin
			end
			ST_OUT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/pps_speed_negotiator.sv -----
// Result path: the input transaction is latched, evaluated and then loaded into the
//   output register; a negotiated ETU first runs a 12-step shift-subtract divider.
// Flow: one item at a time; the next is accepted once the result is loaded. A stalled
//   output delays the next item only when the output register is still full.
// Reset: arst_n clears the negotiation state, the controller and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module pps_speed_negotiator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// requested_pps1, link_ok, atr_len, atr_format, atr_second, atr_third,
	// atr_fourth, atr_fifth, response_word, zero pad
	input  wire logic [psn_pkg::S_TDATA_W-1:0]     s_tdata,
	// op
	input  wire logic [psn_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// request_word, reported_pps1, etu, protocol, zero pad
	output logic [psn_pkg::M_TDATA_W-1:0]          m_tdata,
	// kind
	output logic [psn_pkg::M_TUSER_W-1:0]          m_tuser
);
	import psn_pkg::*;

	psn_cmd_t cmd;
	psn_sts_t sts;

	psn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

	// One item in flight: no new transaction right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// Divider is never restarted mid-division
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// A result never overwrites one that has not been taken
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.out_load)
		else $error("output register overwritten");

	// Loading a result always shows it on the next cycle
	a_out_show: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

endmodule

`default_nettype wire
